>>> rtl/amq_pkg.sv
// shared types and constants for the absmax int8 vector quantizer
// no dependencies

package amq_pkg;

    localparam int MAX_WORDS = 64;
    localparam int LANES     = 8;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int QBITS     = 8;

    localparam logic [1:0] REG_BIASED_MODE = 2'd0;

    typedef struct packed {
        logic [15:0] sample_0;
        logic [15:0] sample_1;
        logic [15:0] sample_2;
        logic [15:0] sample_3;
        logic [15:0] sample_4;
        logic [15:0] sample_5;
        logic [15:0] sample_6;
        logic [15:0] sample_7;
        logic [3:0]  in_lanes_valid;
        logic        in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  code_0;
        logic [7:0]  code_1;
        logic [7:0]  code_2;
        logic [7:0]  code_3;
        logic [7:0]  code_4;
        logic [7:0]  code_5;
        logic [7:0]  code_6;
        logic [7:0]  code_7;
        logic [3:0]  out_lanes_valid;
        logic [15:0] abs_max;
        logic        out_last;
        logic        overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_WAIT,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } state_t;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic [16:0] mag;
        logic [16:0] amax;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] q;
    } div_rsp_t;

endpackage

>>> rtl/amq_divider.sv
// restoring divider, one quotient bit per cycle: (254*mag + amax) / (2*amax)
// quotient saturated to 128; uses amq_pkg

module amq_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  amq_pkg::div_req_t req,
    output amq_pkg::div_rsp_t rsp
);
    import amq_pkg::*;

    // quotient never above 128, so 8 bits plus a saturation check
    localparam int STEPS = QBITS + 1;

    logic [24:0] rem_reg, rem_next;
    logic [17:0] den_reg, den_next;
    logic [8:0]  quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [25:0] trial;
    logic [25:0] shifted_den;

    always_comb
    begin
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        shifted_den = {8'd0, den_reg} << cnt_reg;
        trial       = {1'b0, rem_reg} - shifted_den;
        rsp.done    = done_reg;
        rsp.q       = (quo_reg > 9'd128) ? 8'd128 : quo_reg[7:0];
        if (req.start)
        begin
            rem_next  = {8'd0, req.mag} * 25'd254 + {8'd0, req.amax};
            den_next  = {req.amax, 1'b0};
            quo_next  = '0;
            cnt_next  = 4'(STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one restoring subtract per cycle
            if (!trial[25])
            begin
                rem_next = trial[24:0];
                quo_next = quo_reg | (9'd1 << cnt_reg);
            end
            if (cnt_reg == 4'd0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 4'd1;
        end
    end

    // done flag registered, raised in the cycle after the last step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= busy_reg && !busy_next && !req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

>>> rtl/absmax_int8_vector_quantizer.sv
// top level of the absmax int8 vector quantizer: store, sequencer, apb register
// depends on amq_pkg and amq_divider
//
// Usage: input words (eight 16-bit samples, lane count, last flag) arrive on
// in_data with in_valid/in_stall. Each word is taken while in_stall is low and
// written to a 64-word sample memory while the running absolute maximum is
// updated. A word beyond 64 is dropped and sets the overflow flag.
// On the last word the block stops taking input and emits one result word per
// stored word on out_data with out_valid/out_stall. Each lane goes through one
// shared restoring divider: a start state, 9 steps, the done flag and a move
// to the next lane; each result word also takes a memory read and an output
// state.
// A result waits in the output register while out_stall is high; the
// sequencer holds until it is taken. After the final result the counters and
// maximum clear and input is taken again.
// Reset (rst_n low, asynchronous) clears control state and biased_mode; the
// memory is not cleared and only entries of the current vector are read.
// biased_mode is register 0 on the apb port; the user must write it only when idle, the block does not enforce this.

module absmax_int8_vector_quantizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  amq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output amq_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import amq_pkg::*;

    state_t state_reg, state_next;
    logic   biased_reg;
    logic [CNT_W-1:0]  wcnt_reg, wcnt_next;
    logic [ADDR_W-1:0] ridx_reg, ridx_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [15:0]       amax_reg, amax_next;
    logic              drop_reg, drop_next;
    logic [7:0]        codes_reg [LANES], codes_next [LANES];
    logic              ovalid_reg, ovalid_next;
    out_item_t         odata_reg, odata_next;

    logic [16*LANES-1:0] mem_s [MAX_WORDS];
    logic [3:0]          mem_l [MAX_WORDS];
    logic [16*LANES-1:0] rd_s_reg;
    logic [3:0]          rd_l_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [15:0] in_s [LANES];
    logic [3:0]  in_lanes_sat;
    logic [15:0] word_max;
    logic        accept;

    // apb register
    assign pready = 1'b1;
    assign prdata = {31'd0, biased_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            biased_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == REG_BIASED_MODE)
            biased_reg <= pwdata[0];
    end

    // lane unpack and saturated count
    assign in_s[0] = in_data.sample_0;
    assign in_s[1] = in_data.sample_1;
    assign in_s[2] = in_data.sample_2;
    assign in_s[3] = in_data.sample_3;
    assign in_s[4] = in_data.sample_4;
    assign in_s[5] = in_data.sample_5;
    assign in_s[6] = in_data.sample_6;
    assign in_s[7] = in_data.sample_7;
    assign in_lanes_sat = (in_data.in_lanes_valid > 4'(LANES)) ? 4'(LANES)
                                                               : in_data.in_lanes_valid;

    // word maximum over independent lanes
    always_comb
    begin
        logic [15:0] m;
        word_max = '0;
        for (int k = 0; k < LANES; k++)
        begin
            m = in_s[k][15] ? 16'(-in_s[k]) : in_s[k];
            if (4'(k) < in_lanes_sat && m > word_max)
                word_max = m;
        end
    end

    assign in_stall = (state_reg != ST_LOAD);
    assign accept   = in_valid && !in_stall;

    // sample memory
    always_ff @(posedge clk)
    begin
        if (accept && wcnt_reg < CNT_W'(MAX_WORDS))
        begin
            mem_s[wcnt_reg[ADDR_W-1:0]] <= {in_s[7], in_s[6], in_s[5], in_s[4],
                                            in_s[3], in_s[2], in_s[1], in_s[0]};
            mem_l[wcnt_reg[ADDR_W-1:0]] <= in_lanes_sat;
        end
        rd_s_reg <= mem_s[ridx_reg];
        rd_l_reg <= mem_l[ridx_reg];
    end

    amq_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // current lane sample and code assembly
    logic [15:0] cur_s;
    logic [16:0] cur_mag;
    logic [7:0]  lane_code;
    logic signed [8:0] sq;

    assign cur_s   = rd_s_reg[16*lane_reg +: 16];
    assign cur_mag = cur_s[15] ? 17'(-{cur_s[15], cur_s}) : {1'b0, cur_s};

    always_comb
    begin
        sq = cur_s[15] ? -$signed({1'b0, drsp.q}) : $signed({1'b0, drsp.q});
        if (sq > 9'sd127)
            sq = 9'sd127;
        if (amax_reg == 16'd0)
            sq = 9'sd0;
        lane_code = sq[7:0] + (biased_reg ? 8'h80 : 8'h00);
        if (4'(lane_reg) >= rd_l_reg)
            lane_code = 8'h00;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        wcnt_next   = wcnt_reg;
        ridx_next   = ridx_reg;
        lane_next   = lane_reg;
        amax_next   = amax_reg;
        drop_next   = drop_reg;
        codes_next  = codes_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        dreq.start  = 1'b0;
        dreq.mag    = cur_mag;
        dreq.amax   = {1'b0, amax_reg};

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (wcnt_reg < CNT_W'(MAX_WORDS))
                    begin
                        wcnt_next = wcnt_reg + CNT_W'(1);
                        if (word_max > amax_reg)
                            amax_next = word_max;
                    end
                    else
                        drop_next = 1'b1;
                    if (in_data.in_last)
                    begin
                        ridx_next  = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (wcnt_next == '0)
                    state_next = ST_LOAD;
                else
                begin
                    lane_next  = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                dreq.start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    codes_next[lane_reg] = lane_code;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (lane_reg == LANE_W'(LANES - 1))
                    state_next = ST_OUT;
                else
                begin
                    lane_next  = lane_reg + LANE_W'(1);
                    state_next = ST_WAIT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    odata_next.code_0 = codes_reg[0];
                    odata_next.code_1 = codes_reg[1];
                    odata_next.code_2 = codes_reg[2];
                    odata_next.code_3 = codes_reg[3];
                    odata_next.code_4 = codes_reg[4];
                    odata_next.code_5 = codes_reg[5];
                    odata_next.code_6 = codes_reg[6];
                    odata_next.code_7 = codes_reg[7];
                    odata_next.out_lanes_valid = rd_l_reg;
                    odata_next.abs_max  = amax_reg;
                    odata_next.overflow = drop_reg;
                    if (CNT_W'(ridx_reg) + CNT_W'(1) == wcnt_reg)
                    begin
                        odata_next.out_last = 1'b1;
                        wcnt_next  = '0;
                        amax_next  = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        odata_next.out_last = 1'b0;
                        ridx_next  = ridx_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            wcnt_reg   <= '0;
            ridx_reg   <= '0;
            lane_reg   <= '0;
            amax_reg   <= '0;
            drop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wcnt_reg   <= wcnt_next;
            ridx_reg   <= ridx_next;
            lane_reg   <= lane_next;
            amax_reg   <= amax_next;
            drop_reg   <= drop_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        codes_reg <= codes_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    // input is refused whenever the sequencer is emitting
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> in_stall)
        else $error("input taken during emission");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // word count never exceeds capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= CNT_W'(MAX_WORDS))
        else $error("word count above capacity");

endmodule

>>> sim/amq_checker.sv
// checker for the absmax int8 vector quantizer: watches both channels,
// predicts result words and compares them; depends on amq_pkg
`timescale 1ns / 100ps

module amq_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  amq_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  amq_pkg::out_item_t out_data,
    input  logic               biased_mode,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);
    import amq_pkg::*;

    logic [15:0] vec_samples [MAX_WORDS][LANES];
    logic [3:0]  vec_lanes [MAX_WORDS];
    int          vec_words;
    int          vec_absmax;
    logic        vec_dropped;
    out_item_t   expected_words [$];

    assign pending = expected_words.size();

    // round half away from zero of x*127/amax, clamped, then optionally biased
    function automatic logic [7:0] quantize(logic [15:0] raw, int amax, logic bias);
        int x;
        int mag;
        int q;
        x = $signed(raw);
        mag = (x < 0) ? -x : x;
        q = 0;
        if (amax != 0)
        begin
            q = (2 * mag * 127 + amax) / (2 * amax);
            if (q > 128)
                q = 128;
            if (x < 0)
                q = -q;
            if (q > 127)
                q = 127;
        end
        if (bias)
            q = q + 128;
        return q[7:0];
    endfunction

    // absorb one input transaction, emitting expected words on last
    task automatic absorb_word(in_item_t w);
        logic [15:0] s [LANES];
        int          n;
        int          m;
        logic [7:0]  c [LANES];
        out_item_t   r;
        s = '{w.sample_0, w.sample_1, w.sample_2, w.sample_3,
              w.sample_4, w.sample_5, w.sample_6, w.sample_7};
        n = (w.in_lanes_valid > LANES) ? LANES : w.in_lanes_valid;
        if (vec_words < MAX_WORDS)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                vec_samples[vec_words][k] = s[k];
                if (k < n)
                begin
                    m = $signed(s[k]);
                    if (m < 0)
                        m = -m;
                    if (m > vec_absmax)
                        vec_absmax = m;
                end
            end
            vec_lanes[vec_words] = 4'(n);
            vec_words++;
        end
        else
            vec_dropped = 1'b1;
        if (w.in_last)
        begin
            for (int i = 0; i < vec_words; i++)
            begin
                for (int k = 0; k < LANES; k++)
                    c[k] = (k < vec_lanes[i]) ?
                        quantize(vec_samples[i][k], vec_absmax, biased_mode) : 8'd0;
                r.code_0 = c[0]; r.code_1 = c[1]; r.code_2 = c[2]; r.code_3 = c[3];
                r.code_4 = c[4]; r.code_5 = c[5]; r.code_6 = c[6]; r.code_7 = c[7];
                r.out_lanes_valid = vec_lanes[i];
                r.abs_max = vec_absmax[15:0];
                r.out_last = (i == vec_words - 1);
                r.overflow = vec_dropped;
                expected_words.push_back(r);
            end
            vec_words = 0;
            vec_absmax = 0;
            vec_dropped = 1'b0;
        end
    endtask

    // watch channels and compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_words = 0;
            vec_absmax = 0;
            vec_dropped = 1'b0;
            fail_count <= 0;
            result_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_word(in_data);
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (out_data !== expected_words[0])
                    begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, expected_words[0], out_data);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_words.pop_front());
                end
            end
        end
    end

endmodule

>>> sim/tb_absmax_int8_vector_quantizer.sv
// testbench top for the absmax int8 vector quantizer: drives vectors and the
// apb register, checked by amq_checker; depends on amq_pkg and the rtl
`timescale 1ns / 100ps

module tb_absmax_int8_vector_quantizer;
    import amq_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;
    logic       biased_mode;
    int         fail_count;
    int         cfg_fail;
    int         pending;
    int         result_count;
    int         sent;
    int         vectors;
    int         gap_left;
    int         stall_mode = 0;

    absmax_int8_vector_quantizer i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    amq_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .biased_mode(biased_mode), .fail_count(fail_count),
        .pending(pending), .result_count(result_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver stall pattern: phases of none, light and heavy stall
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial
    begin
        #4000000;
        $display("tb_absmax_int8_vector_quantizer failed");
        $finish;
    end

    // one apb write of the mode register while idle, then a readback
    task automatic write_mode(logic value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_BIASED_MODE; pwdata <= {31'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        biased_mode = value;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
        if (prdata !== {31'd0, value})
        begin
            $display("%0t: register readback expected %h actual %h",
                     $time, {31'd0, value}, prdata);
            cfg_fail++;
        end
    endtask

    // drop valid, then wait until every expected result has come
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // present one input transaction, with a random gap in bursts;
    // valid of the previous transaction is dropped only when a gap follows
    task automatic send_word(in_item_t w);
        if (gap_left == 0 && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 12);
        if (gap_left > 0)
            in_valid <= 1'b0;
        while (gap_left > 0)
        begin
            gap_left--;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic [15:0] pick_sample(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15) - 8);
            2: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
            default: return 16'd0;
        endcase
    endfunction

    // word with given lane count and last flag, random sample style
    function automatic in_item_t make_word(int style, logic [3:0] lanes, logic last);
        in_item_t w;
        w.sample_0 = pick_sample(style); w.sample_1 = pick_sample(style);
        w.sample_2 = pick_sample(style); w.sample_3 = pick_sample(style);
        w.sample_4 = pick_sample(style); w.sample_5 = pick_sample(style);
        w.sample_6 = pick_sample(style); w.sample_7 = pick_sample(style);
        w.in_lanes_valid = lanes;
        w.in_last = last;
        return w;
    endfunction

    task automatic send_vector(int words, int style);
        for (int i = 0; i < words; i++)
            send_word(make_word(($urandom_range(0, 7) == 0) ? 0 : style,
                                4'($urandom_range(0, 15)), i == words - 1));
        vectors++;
    endtask

    initial
    begin
        in_item_t w;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        biased_mode = 1'b0;
        cfg_fail = 0;
        sent = 0; vectors = 0; gap_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero vector, single word, lane counts
        w = make_word(2, 4'd8, 1'b0);
        w.sample_0 = 16'h8000; w.sample_1 = 16'h7fff; w.sample_2 = 16'hffff;
        w.sample_3 = 16'h0001;
        send_word(w);
        send_word(make_word(1, 4'd15, 1'b0));
        send_word(make_word(0, 4'd0, 1'b1));
        vectors++;
        send_word(make_word(3, 4'd8, 1'b1));
        vectors++;
        w = make_word(3, 4'd8, 1'b1);
        w.sample_0 = 16'd127; w.sample_1 = 16'hff81; w.sample_2 = 16'd1;
        w.sample_3 = 16'd63; w.sample_4 = 16'd64; w.sample_5 = 16'hffc1;
        send_word(w);
        vectors++;
        w = make_word(0, 4'd1, 1'b1);
        w.sample_0 = 16'h8000;
        send_word(w);
        vectors++;
        wait_idle();
        write_mode(1'b1);
        send_word(make_word(3, 4'd8, 1'b1));
        send_word(make_word(2, 4'd9, 1'b0));
        send_word(make_word(0, 4'd8, 1'b1));
        vectors += 2;
        // overflow: 66 words, the last two of them dropped
        send_vector(66, 0);
        wait_idle();
        write_mode(1'b0);

        // random vectors, mostly short, a few of 63 to 67 words
        while (sent < 420)
        begin
            if ($urandom_range(0, 9) == 0)
                send_vector($urandom_range(63, 67), $urandom_range(0, 2));
            else
                send_vector($urandom_range(1, 6), $urandom_range(0, 2));
            if ($urandom_range(0, 7) == 0)
            begin
                wait_idle();
                write_mode(1'($urandom_range(0, 1)));
            end
        end
        wait_idle();

        $display("covered %0d input words in %0d vectors, %0d result words checked",
                 sent, vectors, result_count);
        $display("both output modes, zero vectors, full-scale samples and overflow");
        if (fail_count == 0 && cfg_fail == 0)
            $display("tb_absmax_int8_vector_quantizer passed");
        else
            $display("tb_absmax_int8_vector_quantizer failed");
        $finish;
    end

endmodule
